// ----- design/sfp_pkg.sv -----
// Shared constants for the spherical flip point unit.
package sfp_pkg;

    localparam int FIELD_WIDTH       = 32;
    localparam int RADIUS_WIDTH      = 31;
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int CFG_INDEX_WIDTH   = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIUS   = 3'd3;

    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 31'd65536;

endpackage

// ----- design/sfp_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module sfp_isqrt import sfp_pkg::*; #(
    parameter int SW = 68,
    parameter int NW = 33
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [SW-1:0] i_sum,
    output logic [NW-1:0] o_root
);

    logic [NW-1:0] r_root [NW];
    logic [SW-1:0] r_rem  [NW];

    for (genvar j = 0; j < NW; j++) begin : g_stage
        localparam int B = NW - 1 - j;
        logic [NW-1:0] root_in;
        logic [SW-1:0] rem_in;
        logic [SW-1:0] trial;
        logic [NW-1:0] n_root;
        logic [SW-1:0] n_rem;

        if (j == 0) begin : g_first
            assign root_in = '0;
            assign rem_in  = i_sum;
        end else begin : g_next
            assign root_in = r_root[j-1];
            assign rem_in  = r_rem[j-1];
        end

        // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
        assign trial = (SW'(root_in) << (B + 1)) | (SW'(1) << (2 * B));

        always_comb begin
            n_root = root_in;
            n_rem  = rem_in;
            if (trial <= rem_in) begin
                n_root = root_in | (NW'(1) << B);
                n_rem  = rem_in - trial;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[j] <= n_root;
                r_rem[j]  <= n_rem;
            end
        end
    end

    assign o_root = r_root[NW-1];

endmodule

// ----- design/sfp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module sfp_div import sfp_pkg::*; #(
    parameter int PW = 65,
    parameter int NW = 33,
    parameter int KW = 33
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [PW-1:0] i_dividend,
    input  logic [NW-1:0] i_divisor,
    output logic [KW-1:0] o_quot
);

    logic [NW-1:0] r_rem [KW];
    logic [KW-1:0] r_lo  [KW];
    logic [KW-1:0] r_q   [KW];
    logic [NW-1:0] r_dv  [KW];

    for (genvar j = 0; j < KW; j++) begin : g_stage
        logic [NW-1:0] rem_in;
        logic [KW-1:0] lo_in;
        logic [KW-1:0] q_in;
        logic [NW-1:0] dv_in;
        logic [NW:0]   t;
        logic          qbit;
        logic [NW-1:0] n_rem;

        if (j == 0) begin : g_first
            // quotient fits KW bits, so the top part is already below the divisor
            assign rem_in = NW'(i_dividend[PW-1:KW]);
            assign lo_in  = i_dividend[KW-1:0];
            assign q_in   = '0;
            assign dv_in  = i_divisor;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign lo_in  = r_lo[j-1];
            assign q_in   = r_q[j-1];
            assign dv_in  = r_dv[j-1];
        end

        assign t     = {rem_in, lo_in[KW-1]};
        assign qbit  = (t >= {1'b0, dv_in});
        assign n_rem = qbit ? NW'(t - {1'b0, dv_in}) : NW'(t);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_lo[j]  <= {lo_in[KW-2:0], 1'b0};
                r_q[j]   <= {q_in[KW-2:0], qbit};
                r_dv[j]  <= dv_in;
            end
        end
    end

    assign o_quot = r_q[KW-1];

endmodule

// ----- design/spherical_flip_point_unit.sv -----
// Top level of the spherical flip point unit.
//
// channel  dir  handshake                  payload
// s        in   i_s_tvalid / o_s_tready    i_s_tdata  : coord_x, coord_y, coord_z
// m        out  o_m_tvalid / i_m_tready    o_m_tdata  : out_x, out_y, out_z; o_m_tuser
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One point enters per cycle unless the output stalls the pipe; the pipeline depth is set
// by the bit-per-stage square root (NW stages) and divider (KW stages).
// All stages advance together; when the output holds an untaken result and
// i_m_tready is low the whole pipe holds, so nothing is lost or repeated.
// Synchronous active-low reset clears valid bits and sets the configuration registers to their reset values.
module spherical_flip_point_unit import sfp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [3*FIELD_WIDTH-1:0]   i_s_tdata,   // coord_x, coord_y, coord_z
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [3*FIELD_WIDTH-1:0]   o_m_tdata,   // out_x, out_y, out_z
    output logic                       o_m_tuser,   // saturated
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [FIELD_WIDTH-1:0]     i_cfg_data
);

    localparam int DW = (COORD_WIDTH < 33) ? COORD_WIDTH : 33;
    localparam int MW = DW;
    localparam int SW = 2 * MW + 2;
    localparam int NW = MW + 1;
    localparam int KW = (NW > 32) ? NW : 32;
    localparam int PW = MW + KW;

    localparam logic signed [33:0] D_HI = (34'sd1 <<< (DW - 1)) - 34'sd1;
    localparam logic signed [33:0] D_LO = -D_HI - 34'sd1;
    localparam logic signed [63:0] R_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] R_LO = -R_HI - 64'sd1;

    typedef struct packed {
        logic                 flag;
        logic signed [DW-1:0] d0;
        logic signed [DW-1:0] d1;
        logic signed [DW-1:0] d2;
    } t_side_a;

    typedef struct packed {
        logic       flag;
        logic       nz;
        logic [2:0] sgn;
    } t_side_b;

    // configuration
    logic signed [FIELD_WIDTH-1:0] r_cx, r_cy, r_cz;
    logic [RADIUS_WIDTH-1:0]       r_rad;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_rad <= RADIUS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CENTER_X: r_cx  <= i_cfg_data;
                REG_CENTER_Y: r_cy  <= i_cfg_data;
                REG_CENTER_Z: r_cz  <= i_cfg_data;
                REG_RADIUS:   r_rad <= i_cfg_data[RADIUS_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_vout;
    assign en         = !r_vout || i_m_tready;
    assign o_s_tready = en;

    // stage 1: offset with clip
    logic signed [FIELD_WIDTH-1:0] c [3];
    logic signed [DW-1:0] n1_d [3];
    logic [2:0]           clip1;
    logic signed [DW-1:0] r1_d [3];
    logic                 r1_v, r1_flag;

    assign c[0] = r_cx;
    assign c[1] = r_cy;
    assign c[2] = r_cz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [33:0] diff;
            diff = 34'(signed'(i_s_tdata[i*FIELD_WIDTH +: FIELD_WIDTH])) - 34'(c[i]);
            clip1[i] = 1'b0;
            if (diff > D_HI) begin
                n1_d[i]  = DW'(D_HI);
                clip1[i] = 1'b1;
            end else if (diff < D_LO) begin
                n1_d[i]  = DW'(D_LO);
                clip1[i] = 1'b1;
            end else begin
                n1_d[i] = DW'(diff);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d    <= n1_d;
            r1_flag <= |clip1;
        end
    end

    // stage 2: squares
    logic [2*MW-1:0]      r2_sq [3];
    logic signed [DW-1:0] r2_d  [3];
    logic                 r2_v, r2_flag;
    logic [MW-1:0]        mag2  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [DW:0] dx;
            dx      = {r1_d[i][DW-1], r1_d[i]};
            mag2[i] = MW'(dx < 0 ? -dx : dx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= mag2[i] * mag2[i];
            end
            r2_d    <= r1_d;
            r2_flag <= r1_flag;
        end
    end

    // stage 3: sum of squares
    logic [SW-1:0] r3_s;
    t_side_a       r3_side;
    logic          r3_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_s    <= SW'(r2_sq[0]) + SW'(r2_sq[1]) + SW'(r2_sq[2]);
            r3_side <= '{flag: r2_flag, d0: r2_d[0], d1: r2_d[1], d2: r2_d[2]};
        end
    end

    // square root, side data delayed alongside
    logic [NW-1:0] root;
    t_side_a       r_sa [NW];
    logic          r_va [NW];

    sfp_isqrt #(.SW(SW), .NW(NW)) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sum  (r3_s),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa[0] <= r3_side;
            for (int j = 1; j < NW; j++) begin
                r_sa[j] <= r_sa[j-1];
            end
        end
    end

    // stage 4: k = 2R - n
    logic signed [KW:0] k4;
    logic [NW-1:0]      r4_n;
    logic [KW-1:0]      r4_kmag;
    logic               r4_kneg, r4_v;
    t_side_a            r4_side;

    assign k4 = $signed((KW+1)'({r_rad, 1'b0})) - $signed((KW+1)'(root));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_n    <= root;
            r4_kmag <= KW'(k4 < 0 ? -k4 : k4);
            r4_kneg <= k4 < 0;
            r4_side <= r_sa[NW-1];
        end
    end

    // stage 5: products |d| * |k|
    logic [PW-1:0] r5_p [3];
    logic [NW-1:0] r5_n;
    t_side_b       r5_side;
    logic          r5_v;
    logic [MW-1:0] mag5 [3];
    logic [2:0]    dneg5;

    always_comb begin
        logic signed [DW-1:0] dd [3];
        dd[0] = r4_side.d0;
        dd[1] = r4_side.d1;
        dd[2] = r4_side.d2;
        for (int i = 0; i < 3; i++) begin
            logic signed [DW:0] dx;
            dx       = {dd[i][DW-1], dd[i]};
            mag5[i]  = MW'(dx < 0 ? -dx : dx);
            dneg5[i] = dd[i][DW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r5_p[i] <= PW'(mag5[i]) * PW'(r4_kmag);
            end
            r5_n    <= r4_n;
            r5_side <= '{flag: r4_side.flag, nz: (r4_n != '0), sgn: dneg5 ^ {3{r4_kneg}}};
        end
    end

    // division by n
    logic [KW-1:0] quot [3];
    t_side_b       r_sb [KW];
    logic          r_vb [KW];

    for (genvar i = 0; i < 3; i++) begin : g_div
        sfp_div #(.PW(PW), .NW(NW), .KW(KW)) u_div (
            .i_clk      (i_clk),
            .i_en       (en),
            .i_dividend (r5_p[i]),
            .i_divisor  (r5_n),
            .o_quot     (quot[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= r5_side;
            for (int j = 1; j < KW; j++) begin
                r_sb[j] <= r_sb[j-1];
            end
        end
    end

    // stage 6: add center back, clip, output register
    t_side_b                       sb6;
    logic signed [FIELD_WIDTH-1:0] n6_res [3];
    logic [2:0]                    clip6;
    logic [3*FIELD_WIDTH-1:0]      r_out;
    logic                          r_flag, r_nz;

    assign sb6 = r_sb[KW-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [63:0] qs;
            logic signed [63:0] sum;
            qs  = sb6.sgn[i] ? -$signed(64'(quot[i])) : $signed(64'(quot[i]));
            sum = 64'(c[i]) + qs;
            clip6[i] = 1'b0;
            if (!sb6.nz) begin
                n6_res[i] = c[i];
            end else if (sum > R_HI) begin
                n6_res[i] = FIELD_WIDTH'(R_HI);
                clip6[i]  = 1'b1;
            end else if (sum < R_LO) begin
                n6_res[i] = FIELD_WIDTH'(R_LO);
                clip6[i]  = 1'b1;
            end else begin
                n6_res[i] = FIELD_WIDTH'(sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out  <= {n6_res[2], n6_res[1], n6_res[0]};
            r_flag <= sb6.nz && (sb6.flag || (|clip6));
            r_nz   <= sb6.nz;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r5_v   <= 1'b0;
            r_vout <= 1'b0;
            for (int j = 0; j < NW; j++) r_va[j] <= 1'b0;
            for (int j = 0; j < KW; j++) r_vb[j] <= 1'b0;
        end else if (en) begin
            r1_v    <= i_s_tvalid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r_va[0] <= r3_v;
            for (int j = 1; j < NW; j++) r_va[j] <= r_va[j-1];
            r4_v    <= r_va[NW-1];
            r5_v    <= r4_v;
            r_vb[0] <= r5_v;
            for (int j = 1; j < KW; j++) r_vb[j] <= r_vb[j-1];
            r_vout  <= r_vb[KW-1];
        end
    end

    assign o_m_tvalid = r_vout;
    assign o_m_tdata  = r_out;
    assign o_m_tuser  = r_flag;

`ifndef SYNTH
    a_center_maps_to_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vout && !r_nz) |-> (r_out[FIELD_WIDTH-1:0] == r_cx && !r_flag))
        else $error("zero offset point did not map to the center");

    a_root_zero_iff_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_va[NW-1] |-> ((root == '0) ==
            (r_sa[NW-1].d0 == '0 && r_sa[NW-1].d1 == '0 && r_sa[NW-1].d2 == '0)))
        else $error("square root zero does not match zero offset");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

// ----- bench/spherical_flip_point_unit_tb.sv -----
// Self-checking testbench for the spherical flip point unit: stream stimulus, predictor, checks.
`timescale 1ns / 100ps

module spherical_flip_point_unit_tb;
    import sfp_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED     = 3'd7;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED_LOW = 3'd4;
    localparam int SETTLE_CYCLES = 90;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_GAP       = 18;

    typedef struct {
        logic signed [FIELD_WIDTH-1:0] x, y, z;
        int                            gap;
    } t_point_req;

    typedef struct {
        logic signed [FIELD_WIDTH-1:0] x, y, z;
        logic                          sat;
    } t_flip_res;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_s_tvalid;
    logic                       o_s_tready;
    logic [3*FIELD_WIDTH-1:0]   i_s_tdata;
    logic                       o_m_tvalid;
    logic                       i_m_tready;
    logic [3*FIELD_WIDTH-1:0]   o_m_tdata;
    logic                       o_m_tuser;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [FIELD_WIDTH-1:0]     i_cfg_data;

    spherical_flip_point_unit dut (.*);

    // predictor copy of the registers
    logic signed [FIELD_WIDTH-1:0] ctr_x, ctr_y, ctr_z;
    logic [RADIUS_WIDTH-1:0]       rad;

    t_point_req pending_points[$];
    t_flip_res  expected_points[$];
    t_point_req staged;
    bit         have_staged;
    int         send_wait;
    int         recv_wait;
    int         hold_cnt;
    bit         stall_request, stall_taken;
    bit         recv_busy_mode;
    bit         sender_busy;
    int         errors, cycles, points_in, points_out, sat_seen, cfg_writes;

    // result taken at the last rising edge
    logic o_m_tvalid_seen;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [FIELD_WIDTH-1:0] clip32(
        input logic signed [127:0] v, inout bit flag);
        if (v > 128'sh7FFFFFFF) begin
            flag = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -128'sh80000000) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return v[FIELD_WIDTH-1:0];
    endfunction

    function automatic t_flip_res flip_point(input logic signed [FIELD_WIDTH-1:0] px,
                                             input logic signed [FIELD_WIDTH-1:0] py,
                                             input logic signed [FIELD_WIDTH-1:0] pz);
        logic signed [127:0] ctr[3];
        logic signed [127:0] pin[3];
        logic signed [127:0] off[3];
        logic signed [127:0] kk, qs;
        logic [127:0]        sum, mag, len, trial, kmag, q;
        logic signed [FIELD_WIDTH-1:0] res[3];
        bit                  flag;
        t_flip_res           r;
        flag = 1'b0;
        ctr[0] = ctr_x; ctr[1] = ctr_y; ctr[2] = ctr_z;
        pin[0] = px;    pin[1] = py;    pin[2] = pz;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            off[i] = clip32(pin[i] - ctr[i], flag);
            mag = off[i] < 0 ? -off[i] : off[i];
            sum += mag * mag;
        end
        len = '0;
        for (int b = 56; b >= 0; b--) begin
            trial = len | (128'd1 << b);
            if (trial * trial <= sum) len = trial;
        end
        if (len == 0) begin
            for (int i = 0; i < 3; i++) res[i] = ctr[i][FIELD_WIDTH-1:0];
            flag = 1'b0;
        end else begin
            kk = 2 * $signed({97'd0, rad}) - $signed(len);
            kmag = kk < 0 ? -kk : kk;
            for (int i = 0; i < 3; i++) begin
                mag = off[i] < 0 ? -off[i] : off[i];
                q = (mag * kmag) / len;
                qs = $signed(q);
                if ((off[i] < 0) != (kk < 0)) qs = -qs;
                res[i] = clip32(ctr[i] + qs, flag);
            end
        end
        r.x = res[0]; r.y = res[1]; r.z = res[2]; r.sat = flag;
        return r;
    endfunction

    // request and register acceptance, predictor update, result checks
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("DONE: errors detected");
            $finish;
        end
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                case (i_cfg_index)
                    REG_CENTER_X: ctr_x = i_cfg_data;
                    REG_CENTER_Y: ctr_y = i_cfg_data;
                    REG_CENTER_Z: ctr_z = i_cfg_data;
                    REG_RADIUS:   rad   = i_cfg_data[RADIUS_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                expected_points.insert(expected_points.size(),
                                       flip_point(i_s_tdata[31:0], i_s_tdata[63:32],
                                                  i_s_tdata[95:64]));
                points_in++;
                sender_busy = 1'b0;
            end
            if (o_m_tvalid && i_m_tready) begin
                t_flip_res exp_r;
                points_out++;
                if (o_m_tuser) sat_seen++;
                if (expected_points.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result tdata=%h tuser=%b", $time,
                             o_m_tdata, o_m_tuser);
                end else begin
                    exp_r = expected_points.pop_front();
                    if (o_m_tdata[31:0] !== exp_r.x) begin
                        errors++;
                        $display("%0t: out_x expected %h actual %h", $time, exp_r.x,
                                 o_m_tdata[31:0]);
                    end
                    if (o_m_tdata[63:32] !== exp_r.y) begin
                        errors++;
                        $display("%0t: out_y expected %h actual %h", $time, exp_r.y,
                                 o_m_tdata[63:32]);
                    end
                    if (o_m_tdata[95:64] !== exp_r.z) begin
                        errors++;
                        $display("%0t: out_z expected %h actual %h", $time, exp_r.z,
                                 o_m_tdata[95:64]);
                    end
                    if (o_m_tuser !== exp_r.sat) begin
                        errors++;
                        $display("%0t: saturated expected %b actual %b", $time, exp_r.sat,
                                 o_m_tuser);
                    end
                end
            end
        end
    end

    // request driver; a request on the bus stays until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!(i_s_tvalid && sender_busy)) begin
            if (!have_staged && pending_points.size() > 0) begin
                staged = pending_points.pop_front();
                send_wait = staged.gap;
                have_staged = 1'b1;
            end
            if (have_staged && send_wait == 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {staged.z, staged.y, staged.x};
                have_staged = 1'b0;
                sender_busy = 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
                if (have_staged) send_wait--;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (stall_request && !stall_taken) begin
                hold_cnt = 400;
                stall_taken = 1'b1;
            end
            if (i_m_tready && o_m_tvalid_seen) begin
                if (points_out % 50 == 0) recv_busy_mode = !recv_busy_mode;
                recv_wait = recv_busy_mode ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) o_m_tvalid_seen <= o_m_tvalid && i_m_tready;

    task automatic add_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input bit busy);
        t_point_req p;
        p.x = x; p.y = y; p.z = z;
        p.gap = busy ? $urandom_range(0, MAX_GAP) : 0;
        pending_points.insert(pending_points.size(), p);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_points.size() != 0 || have_staged || i_s_tvalid ||
               expected_points.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz, input logic [31:0] r);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, r);
    endtask

    // random points: mostly near the center so the flip stays in range, some full-range
    task automatic random_points(input int count);
        bit busy;
        logic [31:0] span;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) busy = $urandom_range(0, 2) != 0;
            case ($urandom_range(0, 9))
                0: add_point(ctr_x, ctr_y, ctr_z, busy);
                1, 2, 3: add_point($urandom, $urandom, $urandom, busy);
                default: begin
                    span = 32'd1 << $urandom_range(0, 24);
                    add_point(ctr_x + $signed($urandom % span) - $signed(span >> 1),
                              ctr_y + $signed($urandom % span) - $signed(span >> 1),
                              ctr_z + $signed($urandom % span) - $signed(span >> 1), busy);
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        ctr_x = '0; ctr_y = '0; ctr_z = '0;
        rad = RADIUS_RESET;
        have_staged = 1'b0; sender_busy = 1'b0;
        send_wait = 0; recv_wait = 0; hold_cnt = 0;
        stall_request = 1'b0; stall_taken = 1'b0; recv_busy_mode = 1'b1;
        errors = 0; cycles = 0; points_in = 0; points_out = 0;
        sat_seen = 0; cfg_writes = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset config: center, unit axes, extremes, on the sphere
        add_point(0, 0, 0, 0);
        add_point(32'h0001_0000, 0, 0, 0);
        add_point(0, 32'hFFFF_0000, 0, 0);
        add_point(0, 0, 32'h0000_8000, 0);
        add_point(1, 0, 0, 0);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        add_point(32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 0);
        random_points(50);
        wait_idle();

        // extreme center, zero radius: offsets clip, reflection through the center
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
        add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 0);
        add_point(0, 0, 32'h8000_0000, 0);
        random_points(40);
        wait_idle();

        // largest radius; out-of-range index must leave registers alone
        set_config(32'h0010_0000, 32'hFFF0_0000, 32'h0000_1234, 32'h7FFF_FFFF);
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        write_reg(REG_UNUSED_LOW, 32'h1234_5678);
        add_point(32'h0010_0000, 32'hFFF0_0000, 32'h0000_1234, 0);
        add_point(32'h0010_0001, 32'hFFF0_0000, 32'h0000_1234, 0);
        add_point(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 0);
        random_points(40);
        // long receiver hold-off while requests keep coming
        stall_request = 1'b1;
        random_points(60);
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            set_config($urandom, $urandom, $urandom, $urandom & 32'h7FFF_FFFF);
            random_points(30);
            wait_idle();
            set_config($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                       $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                       $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000,
                       $urandom_range(0, 32'h0040_0000));
            random_points(30);
            wait_idle();
        end

        $display("Sent %0d points, checked %0d results (%0d saturated), %0d register writes",
                 points_in, points_out, sat_seen, cfg_writes);
        $display("Configs covered reset, zero and largest radius, extreme centers, long stall");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
